// ===== rtl/core/qcp_pkg.sv =====
// ---------------------------------------------------------------------------
// qcp_pkg
// Shared types and constants for the quadruple constant propagation and
// folding unit.
// ---------------------------------------------------------------------------
package qcp_pkg;

	localparam int VAR_W  = 6;
	localparam int LIT_W  = 30;
	localparam int DATA_W = 32;
	localparam int OP_W   = 3;

	localparam logic [OP_W-1:0] OP_COPY  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV   = 3'd4;
	localparam logic [OP_W-1:0] OP_OTHER = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]  op_code;
		logic             src1_is_lit;
		logic [LIT_W-1:0] src1_lit;
		logic [VAR_W-1:0] src1_var;
		logic             src2_is_lit;
		logic [LIT_W-1:0] src2_lit;
		logic [VAR_W-1:0] src2_var;
		logic [VAR_W-1:0] dest_var;
		logic             end_of_block;
	} quad_in_t;

	typedef struct packed {
		logic [OP_W-1:0]          res_op;
		logic                     res1_is_lit;
		logic signed [DATA_W-1:0] res1_value;
		logic [VAR_W-1:0]         res1_var;
		logic                     res2_is_lit;
		logic [LIT_W-1:0]         res2_value;
		logic [VAR_W-1:0]         res2_var;
		logic                     res2_empty;
		logic [VAR_W-1:0]         res_dest;
	} quad_out_t;

	// Command from the sequencer to the shared arithmetic unit.
	typedef struct packed {
		logic            start;
		logic [OP_W-1:0] op;
	} alu_ctrl_t;

	// Status from the shared arithmetic unit back to the sequencer.
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_stat_t;

endpackage

// ===== rtl/core/qcp_ram.sv =====
// ---------------------------------------------------------------------------
// qcp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module qcp_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/qcp_alu.sv =====
// ---------------------------------------------------------------------------
// qcp_alu
// Shared iterative arithmetic unit: one 32-bit adder/subtractor does add and
// subtract in one step, and shift-add multiply and restoring divide one bit
// per step.
// ---------------------------------------------------------------------------
module qcp_alu (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qcp_pkg::alu_ctrl_t       ctrl,
	input  logic [qcp_pkg::LIT_W-1:0] opa,
	input  logic [qcp_pkg::LIT_W-1:0] opb,
	output qcp_pkg::alu_stat_t       stat
);
	import qcp_pkg::*;

	localparam int CntW = $clog2(LIT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [OP_W-1:0]   op_q;
	logic [CntW-1:0]   cnt_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] y_q;
	logic [DATA_W-1:0] res_q;

	logic [DATA_W-1:0] add_a;
	logic [DATA_W-1:0] add_b;
	logic              add_sub;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] rem_shift;
	logic              last_step;

	assign rem_shift = {acc_q[DATA_W-2:0], x_q[LIT_W-1]};

	always_comb begin
		add_a   = x_q;
		add_b   = y_q;
		add_sub = 1'b0;
		unique case (op_q)
			OP_SUB: begin
				add_sub = 1'b1;
			end
			OP_MUL: begin
				add_a = acc_q;
				add_b = y_q[0] ? x_q : '0;
			end
			OP_DIV: begin
				add_a   = rem_shift;
				add_b   = y_q;
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	// The carry out of a subtraction is high when there is no borrow.
	assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {{DATA_W{1'b0}}, add_sub};
	assign last_step = (cnt_q == CntW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_ADD;
			cnt_q  <= '0;
		end else begin
			done_q <= !ctrl.start && busy_q && last_step;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctrl.op;
				cnt_q  <= (ctrl.op == OP_MUL || ctrl.op == OP_DIV) ? CntW'(LIT_W) : CntW'(1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= '0;
			x_q   <= {{(DATA_W-LIT_W){1'b0}}, opa};
			y_q   <= {{(DATA_W-LIT_W){1'b0}}, opb};
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: begin
					acc_q <= sum[DATA_W-1:0];
					x_q   <= {x_q[DATA_W-2:0], 1'b0};
					y_q   <= {1'b0, y_q[DATA_W-1:1]};
					if (last_step) begin
						res_q <= sum[DATA_W-1:0];
					end
				end
				OP_DIV: begin
					acc_q <= sum[DATA_W] ? sum[DATA_W-1:0] : rem_shift;
					x_q   <= {{(DATA_W-LIT_W){1'b0}}, x_q[LIT_W-2:0], sum[DATA_W]};
					if (last_step) begin
						res_q <= {{(DATA_W-LIT_W){1'b0}}, x_q[LIT_W-2:0], sum[DATA_W]};
					end
				end
				default: begin
					res_q <= sum[DATA_W-1:0];
				end
			endcase
		end
	end

	assign stat.done   = done_q;
	assign stat.result = res_q;

endmodule

// ===== rtl/core/quad_const_prop_fold_unit.sv =====
// ---------------------------------------------------------------------------
// quad_const_prop_fold_unit
// Constant propagation and folding over a stream of three-address
// quadruples, one quadruple per transfer, with bindings kept per variable.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  src       in         src_valid / src_stall    qcp_pkg::quad_in_t
//  res       out        res_valid / res_stall    qcp_pkg::quad_out_t
//
// An item that is not folded passes through S_IDLE, S_RD1, S_RD2, S_FOLD and S_OUT;
// a folded add, subtract, multiply or divide also waits in S_CALC for the
// shared unit, which resolves a multiply or divide one bit per cycle. Both
// operands are read in turn through the single read port of the binding memory.
// Reset clears all bindings; the binding values need no clearing pass.
// A stalled result holds in its output register; the next item is taken
// meanwhile and waits only at its own write-out.
module quad_const_prop_fold_unit #(
	parameter int VAR_COUNT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  qcp_pkg::quad_in_t  src_item,
	output logic               res_valid,
	input  logic               res_stall,
	output qcp_pkg::quad_out_t res_item
);
	import qcp_pkg::*;

	localparam int VarSpan = 1 << VAR_W;
	localparam int Depth   = (VAR_COUNT < VarSpan) ? VAR_COUNT : VarSpan;
	localparam int AddrW   = $clog2(Depth);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_RD2  = 3'd2;
	localparam logic [2:0] S_FOLD = 3'd3;
	localparam logic [2:0] S_CALC = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]        state_q;
	quad_in_t          item_q;
	logic [Depth-1:0]  bound_q;
	logic              l1_q;
	logic [LIT_W-1:0]  v1_q;
	logic              l2_q;
	logic [LIT_W-1:0]  v2_q;
	logic              fold_q;
	logic [DATA_W-1:0] fold_res_q;
	logic              res_valid_q;
	quad_out_t         res_item_q;

	logic [VAR_W:0]    depth_c;
	logic              src1_hit;
	logic              src2_hit;
	logic              dest_free;
	logic              bind_we;
	logic              can_fold;
	logic              can_load;
	logic [AddrW-1:0]  ram_raddr;
	logic [LIT_W-1:0]  ram_rdata;
	alu_ctrl_t         alu_ctrl;
	alu_stat_t         alu_stat;
	quad_out_t         res_next;

	assign depth_c = (VAR_W+1)'(Depth);

	// Ids at or beyond the table depth are never bound.
	assign src1_hit  = ({1'b0, item_q.src1_var} < depth_c) ? bound_q[item_q.src1_var[AddrW-1:0]]
	                                                       : 1'b0;
	assign src2_hit  = ({1'b0, item_q.src2_var} < depth_c) ? bound_q[item_q.src2_var[AddrW-1:0]]
	                                                       : 1'b0;
	assign dest_free = ({1'b0, item_q.dest_var} < depth_c) ? !bound_q[item_q.dest_var[AddrW-1:0]]
	                                                       : 1'b0;

	// The first binding wins, so a copy only binds a free destination.
	assign bind_we = (state_q == S_RD2) && (item_q.op_code == OP_COPY) && l1_q && dest_free;

	assign can_fold = l1_q && l2_q
		&& (item_q.op_code == OP_ADD || item_q.op_code == OP_SUB
			|| item_q.op_code == OP_MUL || item_q.op_code == OP_DIV)
		&& !(item_q.op_code == OP_DIV && v2_q == '0);

	assign can_load  = !res_valid_q || !res_stall;
	assign src_stall = (state_q != S_IDLE);
	assign ram_raddr = (state_q == S_IDLE) ? src_item.src1_var[AddrW-1:0]
	                                       : item_q.src2_var[AddrW-1:0];

	assign alu_ctrl.start = (state_q == S_FOLD) && can_fold;
	assign alu_ctrl.op    = item_q.op_code;

	qcp_ram #(
		.WIDTH (LIT_W),
		.DEPTH (Depth)
	) u_bind_ram (
		.clk   (clk),
		.we    (bind_we),
		.waddr (item_q.dest_var[AddrW-1:0]),
		.wdata (v1_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	qcp_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (alu_ctrl),
		.opa    (v1_q),
		.opb    (v2_q),
		.stat   (alu_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bound_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && can_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (src_valid) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					if (bind_we) begin
						bound_q[item_q.dest_var[AddrW-1:0]] <= 1'b1;
					end
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					state_q <= can_fold ? S_CALC : S_OUT;
				end
				S_CALC: begin
					if (alu_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (can_load) begin
						if (item_q.end_of_block) begin
							bound_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && src_valid) begin
			item_q <= src_item;
		end
		if (state_q == S_RD1) begin
			l1_q <= item_q.src1_is_lit || src1_hit;
			v1_q <= item_q.src1_is_lit ? item_q.src1_lit : (src1_hit ? ram_rdata : '0);
		end
		if (state_q == S_RD2) begin
			l2_q <= item_q.src2_is_lit || src2_hit;
			v2_q <= item_q.src2_is_lit ? item_q.src2_lit : (src2_hit ? ram_rdata : '0);
		end
		if (state_q == S_FOLD) begin
			fold_q <= can_fold;
		end
		if (state_q == S_CALC && alu_stat.done) begin
			fold_res_q <= alu_stat.result;
		end
		if (state_q == S_OUT && can_load) begin
			res_item_q <= res_next;
		end
	end

	always_comb begin
		res_next.res_op      = fold_q ? OP_COPY : item_q.op_code;
		res_next.res1_is_lit = l1_q;
		res_next.res1_value  = fold_q ? fold_res_q : {{(DATA_W-LIT_W){1'b0}}, v1_q};
		res_next.res1_var    = l1_q ? '0 : item_q.src1_var;
		res_next.res2_is_lit = l2_q && !fold_q;
		res_next.res2_value  = fold_q ? '0 : v2_q;
		res_next.res2_var    = (fold_q || l2_q) ? '0 : item_q.src2_var;
		res_next.res2_empty  = fold_q;
		res_next.res_dest    = item_q.dest_var;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule
